// ===== rtl/bdg_pkg.sv =====
package bdg_pkg;

    localparam int unsigned IDX_W = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_DEBOUNCE_TIME = 2'd0,
        REG_HOLD_TIME     = 2'd1,
        REG_HOLD_MODE     = 2'd2
    } reg_idx_t;

    localparam logic [15:0] DEBOUNCE_RST  = 16'd50;
    localparam logic [31:0] HOLD_RST      = 32'd5000;
    localparam logic        HOLD_MODE_RST = 1'b1;

    typedef struct packed {
        logic [15:0] debounce_time;
        logic [31:0] hold_time;
        logic        hold_mode;
    } cfg_t;

    typedef struct packed {
        logic tare_pending;
        logic send_pending;
        logic debounced_level;
    } result_t;

endpackage

// ===== rtl/bdg_gesture.sv =====
module bdg_gesture
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             raw_level,
    input  logic [31:0]      now_ms,
    input  logic             ack_tare,
    input  logic             ack_send,
    input  bdg_pkg::cfg_t    cfg,
    output bdg_pkg::result_t result
);

    logic        last_raw_reg,     last_raw_next;
    logic        stable_reg,       stable_next;
    logic [31:0] change_stamp_reg, change_stamp_next;
    logic [31:0] press_stamp_reg,  press_stamp_next;
    logic        long_fired_reg,   long_fired_next;
    logic        tare_reg,         tare_next;
    logic        send_reg,         send_next;

    logic [31:0] settle_diff;
    logic [31:0] press_diff_old;
    logic [31:0] press_diff_new;
    logic        flip;
    logic        press_now;
    logic        release_now;
    logic        tare_acked;
    logic        send_acked;
    logic        long_cleared;
    logic        fire;

    always_comb
    begin
        last_raw_next     = raw_level;
        change_stamp_next = (raw_level != last_raw_reg) ? now_ms : change_stamp_reg;
        settle_diff       = now_ms - change_stamp_next;
        flip              = (settle_diff >= {16'd0, cfg.debounce_time})
                            && (raw_level != stable_reg);
        press_now         = flip && !raw_level;
        release_now       = flip && raw_level;
        stable_next       = flip ? raw_level : stable_reg;

        tare_acked        = tare_reg && !ack_tare;
        send_acked        = send_reg && !ack_send;

        // press timing, old stamp for the tap rule, restarted on a new press
        press_diff_old    = now_ms - press_stamp_reg;
        press_diff_new    = press_now ? 32'd0 : press_diff_old;
        press_stamp_next  = press_now ? now_ms : press_stamp_reg;
        long_cleared      = press_now ? 1'b0 : long_fired_reg;

        send_next         = send_acked || (release_now && cfg.hold_mode && !long_fired_reg
                            && (press_diff_old < cfg.hold_time));

        fire              = cfg.hold_mode && !stable_next && !long_cleared
                            && (press_diff_new >= cfg.hold_time);
        long_fired_next   = long_cleared || fire;
        tare_next         = tare_acked || (press_now && !cfg.hold_mode) || fire;

        result.tare_pending    = tare_next;
        result.send_pending    = send_next;
        result.debounced_level = stable_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg     <= 1'b1;
            stable_reg       <= 1'b1;
            change_stamp_reg <= 32'd0;
            press_stamp_reg  <= 32'd0;
            long_fired_reg   <= 1'b0;
            tare_reg         <= 1'b0;
            send_reg         <= 1'b0;
        end
        else if (step)
        begin
            last_raw_reg     <= last_raw_next;
            stable_reg       <= stable_next;
            change_stamp_reg <= change_stamp_next;
            press_stamp_reg  <= press_stamp_next;
            long_fired_reg   <= long_fired_next;
            tare_reg         <= tare_next;
            send_reg         <= send_next;
        end
    end

endmodule

// ===== rtl/button_debounce_gesture.sv =====
// the result of a sample is registered and shows on the outputs in the cycle after it is accepted
// throughput: one sample per cycle; a full result register that is stalled holds the input
// the gesture state update is a single pass of subtract and compare logic
// reset: asynchronous, active low; button taken as released, no events pending,
// debounce_time 50, hold_time 5000, hold_mode 1
module button_debounce_gesture
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [bdg_pkg::IDX_W-1:0] cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     raw_level,
    input  logic [31:0]              now_ms,
    input  logic                     ack_tare,
    input  logic                     ack_send,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     tare_pending,
    output logic                     send_pending,
    output logic                     debounced_level
);

    bdg_pkg::cfg_t    cfg_reg;
    bdg_pkg::result_t result;
    bdg_pkg::result_t result_reg;
    logic             out_valid_reg;
    logic             step;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign step      = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time <= bdg_pkg::DEBOUNCE_RST;
            cfg_reg.hold_time     <= bdg_pkg::HOLD_RST;
            cfg_reg.hold_mode     <= bdg_pkg::HOLD_MODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (bdg_pkg::reg_idx_t'(cfg_index))
                bdg_pkg::REG_DEBOUNCE_TIME: cfg_reg.debounce_time <= cfg_data[15:0];
                bdg_pkg::REG_HOLD_TIME:     cfg_reg.hold_time     <= cfg_data;
                bdg_pkg::REG_HOLD_MODE:     cfg_reg.hold_mode     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    bdg_gesture u_gesture
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .raw_level (raw_level),
        .now_ms    (now_ms),
        .ack_tare  (ack_tare),
        .ack_send  (ack_send),
        .cfg       (cfg_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign tare_pending    = result_reg.tare_pending;
    assign send_pending    = result_reg.send_pending;
    assign debounced_level = result_reg.debounced_level;

endmodule

// ===== rtl/bdg_checker.sv =====
module bdg_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic                      tare_pending,
    input logic                      send_pending,
    input logic                      debounced_level
);

    // stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({tare_pending, send_pending, debounced_level}))
        else $error("stalled result changed or dropped");

    // input held off only by a stalled full result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // accepted request gives a result next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted request produced no result");

    // a new send is only latched on a release
    a_send_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(out_valid) && $past(rst_n) && send_pending && !$past(send_pending)
            |-> debounced_level)
        else $error("send latched while button pressed");

endmodule

bind button_debounce_gesture bdg_checker u_bdg_checker (.*);
